@@ sv/blmp_pkg.sv @@
// Package with shared types, constants and the arctangent table for the mount point block.
`default_nettype none
package blmp_pkg;
	localparam int CORDIC_STEPS = 24;
	localparam int ZW = 34;
	localparam int XW = 34;
	localparam int TW = 17;
	localparam int OUT_W = 19;
	localparam int LEG_W = 3;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int ACC_W = 52;
	localparam int ACC_SHIFT = 29;
	localparam logic [LEG_W-1:0] LAST_LEG = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

	typedef logic signed [TW-1:0] trig_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 neg;
	} cordic_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		unique case (i)
			5'd0: r = 34'sd843314857;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043837;
			5'd3: r = 34'sd133525159;
			5'd4: r = 34'sd67021687;
			5'd5: r = 34'sd33543516;
			5'd6: r = 34'sd16775851;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194283;
			5'd9: r = 34'sd2097149;
			default: r = 34'sd1048576 >>> (i - 5'd10);
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ sv/body_leg_mount_points.sv @@
// Top level of the body leg mount point block.
//   channel | signals                                      | handshake
//   pose    | shift_x shift_z roll/yaw/pitch_angle         | start && !busy
//   cfg     | cfg_we cfg_index cfg_data                    | cfg_we
//   point   | leg_number point_x/y/z final_leg             | result_valid
// A pose yields six leg points; the leg serializer (one point per cycle) sets the rate.
// Poses reach the serializer through the 24-stage CORDIC.
// busy is high only while the serializer would be overrun; a new pose is refused while busy.
// Reset clears control and loads register defaults; the receiver cannot stall.
`default_nettype none
module body_leg_mount_points (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] shift_x,
	input  wire logic signed [15:0] shift_z,
	input  wire logic signed [15:0] roll_angle,
	input  wire logic signed [15:0] yaw_angle,
	input  wire logic signed [15:0] pitch_angle,
	input  wire logic               cfg_we,
	input  wire logic [blmp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [blmp_pkg::CFG_W-1:0]     cfg_data,
	output logic                    result_valid,
	output logic [2:0]              leg_number,
	output logic signed [18:0]      point_x,
	output logic signed [18:0]      point_y,
	output logic signed [18:0]      point_z,
	output logic                    final_leg
);
	import blmp_pkg::*;

	// Angle register, CORDIC input register, the steps and the output register.
	localparam int LAT = CORDIC_STEPS + 3;

	logic [CFG_W-1:0] len_q, wid_q, spr_q, hgt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 16'd7680; wid_q <= 16'd2560; spr_q <= 16'd0; hgt_q <= 16'd1280;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LENGTH: len_q <= cfg_data;
				REG_WIDTH:  wid_q <= cfg_data;
				REG_SPREAD: spr_q <= cfg_data;
				REG_HEIGHT: hgt_q <= cfg_data;
			endcase
		end
	end

	// Gap counter keeps poses apart so the serializer never overlaps.
	logic [2:0] gap_q;
	logic acc;
	assign busy = (gap_q != 3'd0);
	assign acc = start && !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= '0;
		else if (acc) gap_q <= 3'd5;
		else if (busy) gap_q <= gap_q - 1'b1;
	end

	// Shift and valid travel alongside the CORDIC stages.
	logic        v_s1 [LAT];
	logic [31:0] sh_s1 [LAT];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) v_s1[i] <= 1'b0;
		end else begin
			v_s1[0] <= acc;
			for (int i = 1; i < LAT; i++) v_s1[i] <= v_s1[i-1];
		end
	end
	always_ff @(posedge clk) begin
		sh_s1[0] <= {shift_x, shift_z};
		for (int i = 1; i < LAT; i++) sh_s1[i] <= sh_s1[i-1];
	end

	trig_t sr, cr, sy, cy, sp, cp;
	logic signed [15:0] ang_r, ang_y, ang_p;
	always_ff @(posedge clk) begin
		ang_r <= roll_angle; ang_y <= yaw_angle; ang_p <= pitch_angle;
	end

	blmp_cordic u_roll  (.clk, .arst_n, .angle(ang_r), .sin_out(sr), .cos_out(cr));
	blmp_cordic u_yaw   (.clk, .arst_n, .angle(ang_y), .sin_out(sy), .cos_out(cy));
	blmp_cordic u_pitch (.clk, .arst_n, .angle(ang_p), .sin_out(sp), .cos_out(cp));

	blmp_legs u_legs (
		.clk, .arst_n,
		.start_in(v_s1[LAT-1]),
		.sx_in(sh_s1[LAT-1][31:16]), .sz_in(sh_s1[LAT-1][15:0]),
		.sr, .cr, .sy, .cy, .sp, .cp,
		.len(len_q), .wid(wid_q), .spr(spr_q), .hgt(hgt_q),
		.strobe(result_valid), .leg_number, .point_x, .point_y, .point_z, .final_leg
	);
endmodule
`default_nettype wire

@@ sv/blmp_cordic.sv @@
// Pipelined sine and cosine unit, one CORDIC step per stage.
`default_nettype none
module blmp_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [15:0] angle,
	output blmp_pkg::trig_t         sin_out,
	output blmp_pkg::trig_t         cos_out
);
	import blmp_pkg::*;

	cordic_t st_s1 [CORDIC_STEPS+1];
	cordic_t st0;
	logic signed [ZW-1:0] z0;
	logic signed [XW-1:0] xr, yr;

	always_comb begin
		z0 = ZW'(angle) <<< 17;
		st0.x = GAIN_Q30;
		st0.y = '0;
		st0.neg = 1'b0;
		st0.z = z0;
		if (z0 > HALF_PI_Q30) begin
			st0.z = z0 - PI_Q30;
			st0.neg = 1'b1;
		end else if (z0 < -HALF_PI_Q30) begin
			st0.z = z0 + PI_Q30;
			st0.neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		st_s1[0] <= st0;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			st_s1[i+1].neg <= st_s1[i].neg;
			if (!st_s1[i].z[ZW-1]) begin
				st_s1[i+1].x <= st_s1[i].x - (st_s1[i].y >>> i);
				st_s1[i+1].y <= st_s1[i].y + (st_s1[i].x >>> i);
				st_s1[i+1].z <= st_s1[i].z - atan_q30(5'(i));
			end else begin
				st_s1[i+1].x <= st_s1[i].x + (st_s1[i].y >>> i);
				st_s1[i+1].y <= st_s1[i].y - (st_s1[i].x >>> i);
				st_s1[i+1].z <= st_s1[i].z + atan_q30(5'(i));
			end
		end
	end

	always_comb begin
		xr = (st_s1[CORDIC_STEPS].x + XW'(32768)) >>> 16;
		yr = (st_s1[CORDIC_STEPS].y + XW'(32768)) >>> 16;
		if (st_s1[CORDIC_STEPS].neg) begin
			xr = -xr;
			yr = -yr;
		end
	end

	always_ff @(posedge clk) begin
		cos_out <= TW'(xr);
		sin_out <= TW'(yr);
	end

	logic unused;
	assign unused = ^{arst_n, xr[XW-1:TW], yr[XW-1:TW]};
endmodule
`default_nettype wire

@@ sv/blmp_legs.sv @@
// Serializer: from registered trig values, forms one leg point per cycle.
`default_nettype none
module blmp_legs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start_in,
	input  wire logic signed [15:0]             sx_in,
	input  wire logic signed [15:0]             sz_in,
	input  wire blmp_pkg::trig_t                sr, cr, sy, cy, sp, cp,
	input  wire logic [blmp_pkg::CFG_W-1:0]     len, wid, spr, hgt,
	output logic                                strobe,
	output logic [blmp_pkg::LEG_W-1:0]          leg_number,
	output logic signed [blmp_pkg::OUT_W-1:0]   point_x,
	output logic signed [blmp_pkg::OUT_W-1:0]   point_y,
	output logic signed [blmp_pkg::OUT_W-1:0]   point_z,
	output logic                                final_leg
);
	import blmp_pkg::*;

	// Pose capture: register the pose; the leg counter steps through legs 0 to 5.
	logic                  act_q;
	logic [LEG_W-1:0]      leg_q;
	logic signed [15:0]    sx_q, sz_q;
	logic signed [15:0]    sx_s1, sz_s1;
	trig_t                 sr_q, cr_q, sy_q, cy_q, sp_q, cp_q;
	logic signed [35:0]    c_s1, s_s1;
	logic                  v_s1, v_s2, v_s3;
	logic [LEG_W-1:0]      leg_s1, leg_s2, leg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			leg_q <= '0;
		end else if (start_in) begin
			act_q <= 1'b1;
			leg_q <= '0;
		end else if (act_q) begin
			leg_q <= leg_q + 1'b1;
			if (leg_q == LAST_LEG) act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_in) begin
			sx_q <= sx_in; sz_q <= sz_in;
			sr_q <= sr; cr_q <= cr; sy_q <= sy; cy_q <= cy; sp_q <= sp; cp_q <= cp;
		end
	end

	// Stage 1: corner components and per-leg length and trig selection.
	logic signed [18:0] lena, lenb, lenc, lend;
	trig_t ta, tb, tc, td;
	logic signed [18:0] d_w;
	logic signed [18:0] l_s, w_s;
	logic signed [18:0] la_s1, lb_s1, lc_s1, ld_s1;
	trig_t ta_s1, tb_s1, tc_s1, td_s1;
	logic                mode0_s1;

	always_comb begin
		l_s = 19'(len);
		w_s = 19'(wid);
		d_w = 19'(wid) + (19'(spr) <<< 1);
		// Generic leg: x = lena*ta (cp), y terms lenb*tb + lenc*tc, z = lend*td.
		lena = '0; lenb = '0; lenc = '0; lend = '0;
		ta = cp_q; tb = sr_q; tc = sp_q; td = cr_q;
		unique case (leg_q)
			3'd1: begin lenb = d_w;  lend = -d_w; end
			3'd2: begin lena = l_s;  lenb = w_s;  lenc = l_s;  lend = -w_s; end
			3'd3: begin lena = l_s;  lenb = -w_s; lenc = l_s;  lend = w_s; end
			3'd4: begin lenb = -d_w; lend = d_w; end
			3'd5: begin lena = -l_s; lenb = -w_s; lenc = -l_s; lend = w_s; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		leg_s1 <= leg_q;
		mode0_s1 <= (leg_q == 3'd0);
		sx_s1 <= sx_q;
		sz_s1 <= sz_q;
		c_s1 <= -(36'(l_s) * 36'(cy_q)) - (36'(w_s) * 36'(sy_q));
		s_s1 <= -(36'(w_s) * 36'(cy_q)) + (36'(l_s) * 36'(sy_q));
		la_s1 <= lena; lb_s1 <= lenb; lc_s1 <= lenc; ld_s1 <= lend;
		ta_s1 <= ta; tb_s1 <= tb; tc_s1 <= tc; td_s1 <= td;
	end

	// Stage 2: products at accumulator scale.
	logic signed [ACC_W-1:0] px_s2, py1_s2, py2_s2, pz_s2;
	logic signed [ACC_W-1:0] sxa_s2, sza_s2, ha_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		leg_s2 <= leg_s1;
		if (mode0_s1) begin
			px_s2  <= ACC_W'(c_s1) * ACC_W'(cp_q);
			py1_s2 <= -(ACC_W'(s_s1) * ACC_W'(sr_q));
			py2_s2 <= ACC_W'(c_s1) * ACC_W'(sp_q);
			pz_s2  <= ACC_W'(s_s1) * ACC_W'(cr_q);
		end else begin
			px_s2  <= (ACC_W'(la_s1) * ACC_W'(ta_s1)) <<< 14;
			py1_s2 <= (ACC_W'(lb_s1) * ACC_W'(tb_s1)) <<< 14;
			py2_s2 <= (ACC_W'(lc_s1) * ACC_W'(tc_s1)) <<< 14;
			pz_s2  <= (ACC_W'(ld_s1) * ACC_W'(td_s1)) <<< 14;
		end
		sxa_s2 <= ACC_W'(sx_s1) <<< ACC_SHIFT;
		sza_s2 <= ACC_W'(sz_s1) <<< ACC_SHIFT;
		ha_s2  <= ACC_W'(hgt) <<< ACC_SHIFT;
	end

	// Stage 3: sums.
	logic signed [ACC_W-1:0] ax_s3, ay_s3, az_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		leg_s3 <= leg_s2;
		ax_s3 <= px_s2 + sxa_s2;
		ay_s3 <= ha_s2 + py1_s2 + py2_s2;
		az_s3 <= pz_s2 + sza_s2;
	end

	// Stage 4: round, saturate, output register.
	function automatic logic signed [OUT_W-1:0] fin(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] v;
		v = (a + (ACC_W'(1) <<< (ACC_SHIFT - 1))) >>> ACC_SHIFT;
		if (v > ACC_W'(262143)) return OUT_W'(262143);
		if (v < -ACC_W'(262144)) return OUT_W'(-262144);
		return OUT_W'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= v_s3;
	end
	always_ff @(posedge clk) begin
		leg_number <= leg_s3;
		final_leg  <= (leg_s3 == LAST_LEG);
		point_x <= fin(ax_s3);
		point_y <= fin(ay_s3);
		point_z <= fin(az_s3);
	end
endmodule
`default_nettype wire

@@ sv/blmp_checker.sv @@
// Port-level checker for the mount point block, bound to the top level.
`default_nettype none
module blmp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       result_valid,
	input wire logic [2:0] leg_number,
	input wire logic       final_leg
);
	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (final_leg == (leg_number == 3'd5))) else $error("final_leg wrong");
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !final_leg |=> result_valid && leg_number == $past(leg_number) + 3'd1)
		else $error("leg sequence broken");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> leg_number <= 3'd5) else $error("leg out of range");
endmodule

bind body_leg_mount_points blmp_checker u_chk (
	.clk, .arst_n, .start, .busy, .result_valid, .leg_number, .final_leg
);
`default_nettype wire
